@@ src/bxrs_pkg.sv @@
// Package for the bounded xorshift random source.
// Holds request codes, generator shift constants and the byte stream response type.
// Depends on nothing; used by bxrs_gen and bounded_xorshift_random_source.
`timescale 1ns / 1ps

package bxrs_pkg;

  localparam int WORD_W = 64;
  localparam int BYTE_W = 8;
  localparam int REQ_W  = 3;
  localparam int LEFT_W = 4;
  localparam int IDX_W  = 3;

  localparam logic [REQ_W-1:0] REQ_U8   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_U16  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_U32  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_U64  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_BOOL = 3'd4;
  localparam logic [REQ_W-1:0] REQ_BND  = 3'd5;

  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 7;
  localparam int SHIFT_C = 17;

  localparam logic [BYTE_W-1:0] BOOL_MASK = 8'h80;

  localparam logic [WORD_W-1:0] SEED_RESET = 64'd1;
  localparam logic [LEFT_W-1:0] BYTES_PER_WORD = 4'd8;

  localparam logic [IDX_W-1:0] LAST_1 = 3'd0;
  localparam logic [IDX_W-1:0] LAST_2 = 3'd1;
  localparam logic [IDX_W-1:0] LAST_4 = 3'd3;
  localparam logic [IDX_W-1:0] LAST_8 = 3'd7;

  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
  } byte_rsp_t;

endpackage

@@ src/bxrs_gen.sv @@
// Byte stream source: xorshift64 generator, held word and byte count.
// A refill runs one shared xor-shift unit through the A, B and C shifts in turn.
// Depends on bxrs_pkg.
`timescale 1ns / 1ps

module bxrs_gen (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         seed_we,
  input  logic [bxrs_pkg::WORD_W-1:0]  seed_val,
  input  logic                         byte_req,
  output bxrs_pkg::byte_rsp_t          rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_B,
    ST_C
  } gen_state_t;

  gen_state_t                        state_r;
  logic [bxrs_pkg::WORD_W-1:0]       gen_r;
  logic [bxrs_pkg::WORD_W-1:0]       held_r;
  logic [bxrs_pkg::WORD_W-1:0]       work_r;
  logic [bxrs_pkg::LEFT_W-1:0]       left_r;

  logic [bxrs_pkg::WORD_W-1:0]       op;
  logic [bxrs_pkg::WORD_W-1:0]       shifted;
  logic [bxrs_pkg::WORD_W-1:0]       xs_res;
  logic                              have_byte;

  assign have_byte = (left_r != '0);
  assign op        = (state_r == ST_IDLE) ? gen_r : work_r;

  always_comb begin
    unique case (state_r)
      ST_IDLE: shifted = op << bxrs_pkg::SHIFT_A;
      ST_B:    shifted = op >> bxrs_pkg::SHIFT_B;
      ST_C:    shifted = op << bxrs_pkg::SHIFT_C;
      default: shifted = '0;
    endcase
  end

  assign xs_res   = op ^ shifted;
  assign rsp.vld  = have_byte;
  assign rsp.data = held_r[bxrs_pkg::BYTE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      gen_r   <= bxrs_pkg::SEED_RESET;
      left_r  <= '0;
    end else if (seed_we) begin
      state_r <= ST_IDLE;
      gen_r   <= seed_val;
      left_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (byte_req && have_byte) begin
            held_r <= held_r >> bxrs_pkg::BYTE_W;
            left_r <= left_r - 1'b1;
          end else if (byte_req) begin
            work_r  <= xs_res;
            state_r <= ST_B;
          end
        end
        ST_B: begin
          work_r  <= xs_res;
          state_r <= ST_C;
        end
        ST_C: begin
          gen_r   <= xs_res;
          held_r  <= xs_res;
          left_r  <= bxrs_pkg::BYTES_PER_WORD;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ src/bounded_xorshift_random_source.sv @@
// Bounded xorshift random source: one request at a time, assembled byte by byte.
// Path from input to out_valid: the draw state takes each byte, waiting on generator refills,
// then the finish state writes the result register; a bounded draw repeats its bytes for every
// rejected candidate. The next request is accepted only after the finish state has written the
// last result, which waits while the result register stays full.
// Reset (synchronous, rst_n low): generator state 1, no held bytes, idle, no result.
`timescale 1ns / 1ps

module bounded_xorshift_random_source (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bxrs_pkg::WORD_W-1:0]     cfg_seed,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bxrs_pkg::REQ_W-1:0]      in_req_type,
  input  logic [bxrs_pkg::WORD_W-1:0]     in_bound,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bxrs_pkg::WORD_W-1:0]     out_value,
  output logic                            out_bad_bound
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_FIN
  } top_state_t;

  typedef enum logic [1:0] {
    K_RAW,
    K_BOOL,
    K_BND
  } kind_t;

  top_state_t                        state_r;
  kind_t                             kind_r;
  logic [bxrs_pkg::WORD_W-1:0]       acc_r;
  logic [bxrs_pkg::WORD_W-1:0]       mask_r;
  logic [bxrs_pkg::WORD_W-1:0]       bound_r;
  logic [bxrs_pkg::IDX_W-1:0]        idx_r;
  logic [bxrs_pkg::IDX_W-1:0]        last_r;
  logic                              bad_r;
  logic                              out_valid_r;
  logic [bxrs_pkg::WORD_W-1:0]       out_value_r;
  logic                              out_bad_r;

  bxrs_pkg::byte_rsp_t               rsp;
  logic                              byte_req;
  logic                              seed_we;
  logic [bxrs_pkg::WORD_W-1:0]       smear;
  logic [bxrs_pkg::IDX_W-1:0]        bnd_last;
  logic [bxrs_pkg::WORD_W-1:0]       acc_nxt;
  logic [bxrs_pkg::WORD_W-1:0]       masked;
  logic                              slot_free;

  assign cfg_ready = 1'b1;
  assign seed_we   = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign byte_req  = (state_r == ST_DRAW);
  assign slot_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_bad_bound = out_bad_r;

  bxrs_gen u_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .seed_we  (seed_we),
    .seed_val (cfg_seed),
    .byte_req (byte_req),
    .rsp      (rsp)
  );

  always_comb begin
    smear = in_bound;
    smear = smear | (smear >> 32);
    smear = smear | (smear >> 16);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 1);
  end

  always_comb begin
    priority if (in_bound <= 64'h0000_0000_0000_00FF) begin
      bnd_last = bxrs_pkg::LAST_1;
    end else if (in_bound < 64'h0000_0000_0000_FFFF) begin
      bnd_last = bxrs_pkg::LAST_2;
    end else if (in_bound < 64'h0000_0000_FFFF_FFFF) begin
      bnd_last = bxrs_pkg::LAST_4;
    end else begin
      bnd_last = bxrs_pkg::LAST_8;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    acc_nxt[{idx_r, 3'b000} +: bxrs_pkg::BYTE_W] = rsp.data;
  end

  assign masked = acc_nxt & mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            acc_r   <= '0;
            idx_r   <= '0;
            mask_r  <= smear;
            bound_r <= in_bound;
            unique case (in_req_type)
              bxrs_pkg::REQ_U8: begin
                kind_r  <= K_RAW;
                last_r  <= bxrs_pkg::LAST_1;
                bad_r   <= 1'b0;
                state_r <= ST_DRAW;
              end
              bxrs_pkg::REQ_U16: begin
                kind_r  <= K_RAW;
                last_r  <= bxrs_pkg::LAST_2;
                bad_r   <= 1'b0;
                state_r <= ST_DRAW;
              end
              bxrs_pkg::REQ_U32: begin
                kind_r  <= K_RAW;
                last_r  <= bxrs_pkg::LAST_4;
                bad_r   <= 1'b0;
                state_r <= ST_DRAW;
              end
              bxrs_pkg::REQ_U64: begin
                kind_r  <= K_RAW;
                last_r  <= bxrs_pkg::LAST_8;
                bad_r   <= 1'b0;
                state_r <= ST_DRAW;
              end
              bxrs_pkg::REQ_BOOL: begin
                kind_r  <= K_BOOL;
                last_r  <= bxrs_pkg::LAST_1;
                bad_r   <= 1'b0;
                state_r <= ST_DRAW;
              end
              bxrs_pkg::REQ_BND: begin
                kind_r  <= K_BND;
                last_r  <= bnd_last;
                bad_r   <= (in_bound == '0);
                state_r <= (in_bound == '0) ? ST_FIN : ST_DRAW;
              end
              default: begin
                kind_r  <= K_RAW;
                last_r  <= bxrs_pkg::LAST_1;
                bad_r   <= 1'b0;
                state_r <= ST_FIN;
              end
            endcase
          end
        end
        ST_DRAW: begin
          if (rsp.vld) begin
            if (idx_r != last_r) begin
              acc_r <= acc_nxt;
              idx_r <= idx_r + 1'b1;
            end else begin
              unique case (kind_r)
                K_BOOL: begin
                  acc_r   <= {{(bxrs_pkg::WORD_W-1){1'b0}},
                              ((rsp.data & bxrs_pkg::BOOL_MASK) == '0)};
                  state_r <= ST_FIN;
                end
                K_BND: begin
                  if (masked < bound_r) begin
                    acc_r   <= masked;
                    state_r <= ST_FIN;
                  end else begin
                    acc_r <= '0;
                    idx_r <= '0;
                  end
                end
                default: begin
                  acc_r   <= acc_nxt;
                  state_r <= ST_FIN;
                end
              endcase
            end
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_value_r <= acc_r;
            out_bad_r   <= bad_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_bound |-> out_value == '0)
    else $error("bad bound result carries a nonzero value");

  a_bnd_below: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && kind_r == K_BND && !bad_r |-> acc_r < bound_r)
    else $error("bounded draw finished at or above its bound");

  a_zero_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == bxrs_pkg::REQ_BND && in_bound == '0
    |=> state_r == ST_FIN && bad_r)
    else $error("zero bound did not go straight to the result");
`endif

endmodule
